// File: hdl/gost_pkg.sv
// Shared types, constants and round helpers for the GOST block cipher.
`default_nettype none
package gost_pkg;

  localparam int GostRounds   = 32;
  localparam int KeyWords     = 8;
  localparam int HalfW        = 32;
  localparam int CfgIdxW      = 4;
  localparam int RotR         = 21;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0 = 4'd0,
    REG_KEY1 = 4'd1,
    REG_KEY2 = 4'd2,
    REG_KEY3 = 4'd3,
    REG_KEY4 = 4'd4,
    REG_KEY5 = 4'd5,
    REG_KEY6 = 4'd6,
    REG_KEY7 = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_e;

  typedef logic [KeyWords-1:0][HalfW-1:0] key_set_t;

  typedef struct packed {
    logic             func;
    logic [HalfW-1:0] half_first;
    logic [HalfW-1:0] half_second;
  } in_t;

  typedef struct packed {
    logic [HalfW-1:0] out_first;
    logic [HalfW-1:0] out_second;
  } out_t;

  // Data carried between round stages
  typedef struct packed {
    logic             func;
    logic [HalfW-1:0] a;
    logic [HalfW-1:0] b;
  } stage_t;

  localparam key_set_t KeyReset = {
    32'h3333_3333, 32'h3333_3333, 32'h4747_4747, 32'h4747_4747,
    32'h3030_3030, 32'h4737_3555, 32'h434D_474E, 32'h4F4C_5544
  };

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'h4, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
      4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h3},
    '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
      4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
    '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
      4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
    '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
      4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
    '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
      4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
    '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
      4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
    '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
      4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
    '{4'h1, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
      4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'hC}
  };

  // Key word used at a given schedule position: forward for all but the
  // last eight positions, which run backward.
  function automatic logic [2:0] key_index(input int pos, input int rounds);
    logic [2:0] low;
    low = pos[2:0];
    if (pos < rounds - KeyWords) begin
      return low;
    end
    return 3'd7 - low;
  endfunction

  // Substitute each nibble through its S-box, then rotate right
  function automatic logic [HalfW-1:0] round_fn(input logic [HalfW-1:0] x);
    logic [HalfW-1:0] s;
    s = '0;
    for (int n = 0; n < 8; n++) begin
      s[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return {s[RotR-1:0], s[HalfW-1:RotR]};
  endfunction

endpackage
`default_nettype wire

// File: hdl/gost_key_regs.sv
// Key register file: eight 32-bit key words written through the config port.
`default_nettype none
module gost_key_regs import gost_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [HalfW-1:0]   cfg_data_i,
  output key_set_t                keys_o
);

  key_set_t keys_q, keys_d;

  // Decode the write; indexes past the key list are dropped
  always_comb begin
    keys_d = keys_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY0: keys_d[0] = cfg_data_i;
        REG_KEY1: keys_d[1] = cfg_data_i;
        REG_KEY2: keys_d[2] = cfg_data_i;
        REG_KEY3: keys_d[3] = cfg_data_i;
        REG_KEY4: keys_d[4] = cfg_data_i;
        REG_KEY5: keys_d[5] = cfg_data_i;
        REG_KEY6: keys_d[6] = cfg_data_i;
        REG_KEY7: keys_d[7] = cfg_data_i;
        default:  keys_d = keys_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= KeyReset;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule
`default_nettype wire

// File: hdl/gost_round.sv
// One Feistel round as a pipeline stage: key add, S-boxes, rotate, XOR, swap.
`default_nettype none
module gost_round import gost_pkg::*; #(
  parameter int Rounds = GostRounds,
  parameter int Round  = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire key_set_t keys_i,
  input  wire logic     valid_i,
  input  wire stage_t   stage_i,
  output logic          valid_o,
  output stage_t        stage_o
);

  localparam logic [2:0] KeyEnc = key_index(Round, Rounds);
  localparam logic [2:0] KeyDec = key_index(Rounds - 1 - Round, Rounds);

  logic       valid_q;
  stage_t     stage_q, stage_d;
  logic [2:0] kidx;

  // Pick the key word for this round's schedule position
  assign kidx = (func_e'(stage_i.func) == FUNC_DEC) ? KeyDec : KeyEnc;

  // Round function on the first half, then trade halves
  always_comb begin
    stage_d.func = stage_i.func;
    stage_d.a    = round_fn(stage_i.a + keys_i[kidx]) ^ stage_i.b;
    stage_d.b    = stage_i.a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

// File: hdl/gost_block_cipher.sv
// Top level: GOST 28147-89 ECB cipher, one round per pipeline stage.
//
//   channel   handshake                 payload
//   input     start_i (busy_o low)      data_i   (func, half_first, half_second)
//   result    done_o  (one-cycle)       result_o (out_first, out_second)
//   config    cfg_we_i, cfg_idx_i       cfg_data_i
//
// Each pipeline stage holds one Feistel round.
// A new block is taken every cycle; busy_o is never raised.
// Reset clears the stage valid bits and loads the default key words.
// Results cannot be held off, so the pipeline never stalls.
`default_nettype none
module gost_block_cipher import gost_pkg::*; #(
  parameter int Rounds = GostRounds
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire in_t                data_i,
  output logic                    done_o,
  output out_t                    result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [HalfW-1:0]   cfg_data_i
);

  key_set_t keys;
  logic     valid [Rounds+1];
  stage_t   stage [Rounds+1];

  gost_key_regs u_keys (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .keys_o     (keys)
  );

  // Feed the beat into the first round
  assign busy_o     = 1'b0;
  assign valid[0]   = start_i;
  assign stage[0].func = data_i.func;
  assign stage[0].a    = data_i.half_first;
  assign stage[0].b    = data_i.half_second;

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    gost_round #(
      .Rounds (Rounds),
      .Round  (r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .keys_i  (keys),
      .valid_i (valid[r]),
      .stage_i (stage[r]),
      .valid_o (valid[r+1]),
      .stage_o (stage[r+1])
    );
  end

  // Undo the last swap on the way out
  assign done_o              = valid[Rounds];
  assign result_o.out_first  = stage[Rounds].b;
  assign result_o.out_second = stage[Rounds].a;

endmodule
`default_nettype wire
